// ----- sv/taa_pkg.sv -----
// Shared types, codes and constants for the tagged allocation accounting block.
// No dependencies; the sequencer, top level and checker import this package.
package taa_pkg;

	// Default table size
	localparam int TABLE_ENTRIES_DEF = 64;

	// Guard words expected at the head and foot of a guarded block
	localparam logic [31:0] HEAD_GUARD_A = 32'h497208AB;
	localparam logic [31:0] HEAD_GUARD_B = 32'h127834DC;
	localparam logic [31:0] FOOT_GUARD_A = 32'h023481A9;
	localparam logic [31:0] FOOT_GUARD_B = 32'hFCB87147;

	localparam int IN_DATA_W  = 192;
	localparam int OUT_DATA_W = 160;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_GUARDED = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_FULL        = 3'd1,
		ST_TAG_UNDER   = 3'd2,
		ST_TOTAL_UNDER = 3'd3,
		ST_HEAD_BAD    = 3'd4,
		ST_FOOT_BAD    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_FETCH,
		S_UPDATE,
		S_SWEEP,
		S_RESP
	} state_t;

	// Input payload, last field in the lowest bits
	typedef struct packed {
		logic [31:0] foot_guard_high;
		logic [31:0] foot_guard_low;
		logic [31:0] head_guard_high;
		logic [31:0] head_guard_low;
		logic [31:0] amount;
		logic [31:0] tag;
	} item_t;

	// Result payload, last field in the lowest bits
	typedef struct packed {
		logic [31:0] total_peak;
		logic [31:0] total_current;
		logic [31:0] tag_at_global_peak;
		logic [31:0] tag_peak;
		logic [31:0] tag_current;
	} result_t;

	// One row of the accounting memory
	typedef struct packed {
		logic [31:0] snap;
		logic [31:0] peak;
		logic [31:0] held;
	} entry_t;

endpackage

// ----- sv/taa_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing; used for the tag memory and the accounting memory.
module taa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/taa_ctrl.sv -----
// Sequencer for tag search, read-modify-write of one entry, snapshot sweep and result output.
// Depends on taa_pkg; drives the tag and accounting memories instantiated in the top level.
module taa_ctrl #(
	parameter int TABLE_ENTRIES = taa_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input transaction
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       in_op,
	input  taa_pkg::item_t                   in_item,
	// result transaction
	output logic                             out_valid,
	input  logic                             out_ready,
	output taa_pkg::status_t                 out_status,
	output taa_pkg::result_t                 out_res,
	// tag memory
	output logic                             tag_we,
	output logic [$clog2(TABLE_ENTRIES)-1:0] tag_waddr,
	output logic [31:0]                      tag_wdata,
	output logic                             tag_re,
	output logic [$clog2(TABLE_ENTRIES)-1:0] tag_raddr,
	input  logic [31:0]                      tag_rdata,
	// accounting memory
	output logic                             data_we,
	output logic [$clog2(TABLE_ENTRIES)-1:0] data_waddr,
	output taa_pkg::entry_t                  data_wdata,
	output logic                             data_re,
	output logic [$clog2(TABLE_ENTRIES)-1:0] data_raddr,
	input  taa_pkg::entry_t                  data_rdata
);
	import taa_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	state_t           state_q, state_d;
	op_t              op_q, op_d;
	logic [31:0]      tag_q, tag_d;
	logic [31:0]      amt_q, amt_d;
	logic [CNT_W-1:0] used_q, used_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [31:0]      gheld_q, gheld_d;
	logic [31:0]      gpeak_q, gpeak_d;
	logic             rd_vld_s1, rd_vld_d;
	logic [IDX_W-1:0] rd_idx_s1, rd_idx_d;
	logic [IDX_W-1:0] entry_q, entry_d;
	logic             new_q, new_d;
	status_t          status_q, status_d;
	entry_t           res_q, res_d;
	logic             out_valid_q;
	status_t          out_status_q;
	result_t          out_res_q;
	logic             load_out;

	entry_t           cur_e;
	entry_t           upd_e;
	logic [31:0]      add_held, sub_held, add_tot, sub_tot;
	logic             peak_rise;
	logic             hit;
	logic             more;

	// Arithmetic on the fetched entry
	assign cur_e     = new_q ? '0 : data_rdata;
	assign add_held  = cur_e.held + amt_q;
	assign sub_held  = cur_e.held - amt_q;
	assign add_tot   = gheld_q + amt_q;
	assign sub_tot   = gheld_q - amt_q;
	assign peak_rise = gpeak_q < add_tot;

	assign hit  = rd_vld_s1 && (tag_rdata == tag_q);
	assign more = idx_q != used_q;

	// Next state, memory strobes and datapath updates
	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		tag_d      = tag_q;
		amt_d      = amt_q;
		used_d     = used_q;
		idx_d      = idx_q;
		gheld_d    = gheld_q;
		gpeak_d    = gpeak_q;
		rd_vld_d   = 1'b0;
		rd_idx_d   = idx_q[IDX_W-1:0];
		entry_d    = entry_q;
		new_d      = new_q;
		status_d   = status_q;
		res_d      = res_q;
		upd_e      = cur_e;
		load_out   = 1'b0;
		in_ready   = 1'b0;
		tag_we     = 1'b0;
		tag_waddr  = used_q[IDX_W-1:0];
		tag_wdata  = tag_q;
		tag_re     = 1'b0;
		tag_raddr  = idx_q[IDX_W-1:0];
		data_we    = 1'b0;
		data_waddr = entry_q;
		data_wdata = cur_e;
		data_re    = 1'b0;
		data_raddr = entry_q;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d     = op_t'(in_op);
					tag_d    = in_item.tag;
					amt_d    = in_item.amount;
					idx_d    = '0;
					new_d    = 1'b0;
					status_d = ST_OK;
					res_d    = '0;
					case (op_t'(in_op))
						OP_ALLOC, OP_RELEASE: begin
							state_d = S_SEARCH;
						end
						OP_GUARDED: begin
							// check guards before touching the table
							if (in_item.head_guard_low != HEAD_GUARD_A ||
								in_item.head_guard_high != HEAD_GUARD_B) begin
								status_d = ST_HEAD_BAD;
								state_d  = S_RESP;
							end else if (in_item.foot_guard_low != FOOT_GUARD_A ||
								in_item.foot_guard_high != FOOT_GUARD_B) begin
								status_d = ST_FOOT_BAD;
								state_d  = S_RESP;
							end else begin
								state_d = S_SEARCH;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end

			S_SEARCH: begin
				if (hit) begin
					// found the tag; stop the tag scan
					entry_d = rd_idx_s1;
					state_d = S_FETCH;
				end else if (!more) begin
					if (used_q == FULL_CNT) begin
						status_d = ST_FULL;
						res_d    = '0;
						state_d  = S_RESP;
					end else begin
						// create a fresh zeroed entry at the fill point
						tag_we  = 1'b1;
						entry_d = used_q[IDX_W-1:0];
						new_d   = 1'b1;
						used_d  = used_q + 1'b1;
						state_d = S_UPDATE;
					end
				end else begin
					// advance the tag scan by one entry
					tag_re   = 1'b1;
					rd_vld_d = 1'b1;
					idx_d    = idx_q + 1'b1;
				end
			end

			S_FETCH: begin
				data_re = 1'b1;
				state_d = S_UPDATE;
			end

			S_UPDATE: begin
				state_d = S_RESP;
				case (op_q)
					OP_ALLOC: begin
						upd_e.held = add_held;
						upd_e.peak = (cur_e.peak < add_held) ? add_held : cur_e.peak;
						upd_e.snap = peak_rise ? add_held : cur_e.snap;
						gheld_d    = add_tot;
						status_d   = ST_OK;
						if (peak_rise) begin
							gpeak_d = add_tot;
							idx_d   = '0;
							state_d = S_SWEEP;
						end
					end
					default: begin
						upd_e.held = sub_held;
						if (amt_q > cur_e.held) begin
							status_d = ST_TAG_UNDER;
						end else begin
							gheld_d  = sub_tot;
							status_d = (amt_q > gheld_q) ? ST_TOTAL_UNDER : ST_OK;
						end
					end
				endcase
				data_we    = 1'b1;
				data_wdata = upd_e;
				res_d      = upd_e;
			end

			S_SWEEP: begin
				// read one entry, write its snapshot back the next cycle
				if (more) begin
					data_re    = 1'b1;
					data_raddr = idx_q[IDX_W-1:0];
					rd_vld_d   = 1'b1;
					idx_d      = idx_q + 1'b1;
				end
				if (rd_vld_s1) begin
					data_we         = 1'b1;
					data_waddr      = rd_idx_s1;
					data_wdata.held = data_rdata.held;
					data_wdata.peak = data_rdata.peak;
					data_wdata.snap = data_rdata.held;
				end
				if (!more && !rd_vld_s1) begin
					state_d = S_RESP;
				end
			end

			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and global counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			gheld_q     <= '0;
			gpeak_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			used_q    <= used_d;
			gheld_q   <= gheld_d;
			gpeak_q   <= gpeak_d;
			rd_vld_s1 <= rd_vld_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		op_q      <= op_d;
		tag_q     <= tag_d;
		amt_q     <= amt_d;
		idx_q     <= idx_d;
		rd_idx_s1 <= rd_idx_d;
		entry_q   <= entry_d;
		new_q     <= new_d;
		status_q  <= status_d;
		res_q     <= res_d;
		if (load_out) begin
			out_status_q               <= status_q;
			out_res_q.tag_current      <= res_q.held;
			out_res_q.tag_peak         <= res_q.peak;
			out_res_q.tag_at_global_peak <= res_q.snap;
			out_res_q.total_current    <= gheld_q;
			out_res_q.total_peak       <= gpeak_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_res    = out_res_q;

endmodule

// ----- sv/tagged_alloc_accounting_top.sv -----
// Sequence: a guard failure or unused op goes straight to the result; a table operation scans
// the tags in use, then fetches and updates one entry, and sweeps them when the global peak rises.
// Throughput: one transaction at a time; the tag scan and snapshot sweep through the
// single-read-port memories set the rate.
// Reset: arst_n clears the fill count, global totals and handshake state at once; the
// memories need no clearing since only filled entries are ever read.
module tagged_alloc_accounting_top #(
	parameter int TABLE_ENTRIES = taa_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tag, amount, head_guard_low, head_guard_high, foot_guard_low, foot_guard_high
	input  logic [taa_pkg::IN_DATA_W-1:0]   s_tdata,
	// op
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tag_current, tag_peak, tag_at_global_peak, total_current, total_peak
	output logic [taa_pkg::OUT_DATA_W-1:0]  m_tdata,
	// status
	output logic [2:0]                      m_tuser
);
	import taa_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int ENTRY_W = $bits(entry_t);

	logic             tag_we, tag_re, data_we, data_re;
	logic [IDX_W-1:0] tag_waddr, tag_raddr, data_waddr, data_raddr;
	logic [31:0]      tag_wdata, tag_rdata;
	entry_t           data_wdata, data_rdata;
	logic [ENTRY_W-1:0] data_rword;
	status_t          out_status;
	result_t          out_res;

	// Tag memory
	taa_ram #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (32)
	) u_tag_mem (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.re    (tag_re),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	// Accounting memory: held, peak and snapshot per entry
	taa_ram #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (ENTRY_W)
	) u_data_mem (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (ENTRY_W'(data_wdata)),
		.re    (data_re),
		.raddr (data_raddr),
		.rdata (data_rword)
	);

	assign data_rdata = entry_t'(data_rword);

	// Sequencer
	taa_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_item    (item_t'(s_tdata)),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_res    (out_res),
		.tag_we     (tag_we),
		.tag_waddr  (tag_waddr),
		.tag_wdata  (tag_wdata),
		.tag_re     (tag_re),
		.tag_raddr  (tag_raddr),
		.tag_rdata  (tag_rdata),
		.data_we    (data_we),
		.data_waddr (data_waddr),
		.data_wdata (data_wdata),
		.data_re    (data_re),
		.data_raddr (data_raddr),
		.data_rdata (data_rdata)
	);

	// Pack the result
	assign m_tdata = OUT_DATA_W'(out_res);
	assign m_tuser = 3'(out_status);

endmodule

// ----- sv/taa_checker.sv -----
// Port-level checks for the tagged allocation accounting block, bound to the top level.
// Depends on taa_pkg for the status codes and payload widths.
module taa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [taa_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [2:0]                     m_tuser
);
	import taa_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Take one item at a time: ready drops after an accepted transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction accepted while busy");

	// Zero the tag fields for a full table or a bad guard, where no entry was touched
	a_zero_tag_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_HEAD_BAD || m_tuser == ST_FOOT_BAD)
		|-> m_tdata[95:0] == 96'd0)
		else $error("tag fields not zero for a rejected transaction");

endmodule

bind tagged_alloc_accounting_top taa_checker u_taa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
